/* hdl/height_checkpoint_table_macros.svh */
// Assertion macros shared by the checker of the checkpoint table.
// No dependencies; include by bare file name inside a module body.
`ifndef HEIGHT_CHECKPOINT_TABLE_MACROS_SVH
`define HEIGHT_CHECKPOINT_TABLE_MACROS_SVH

// same-cycle implication under the synchronous active-low reset
`define HCT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("checkpoint table: same-cycle check failed");

// next-cycle implication under the synchronous active-low reset
`define HCT_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("checkpoint table: next-cycle check failed");

`endif

/* hdl/hct_pkg.sv */
// Types and codes of the height checkpoint table.
// No dependencies; imported by the compare unit, the top level and the checker.
`timescale 1ns / 1ps

package hct_pkg;

    localparam int HEIGHT_W = 64;
    localparam int HASH_W   = 256;

    localparam logic [1:0] REQ_INSERT = 2'd0;
    localparam logic [1:0] REQ_CHECK  = 2'd1;
    localparam logic [1:0] REQ_QUERY  = 2'd2;
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_CONFLICT = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_ZONE = 5'b00010,
        S_SCAN = 5'b00100,
        S_HRD  = 5'b01000,
        S_FIN  = 5'b10000
    } t_state;

    typedef struct packed {
        logic eq;
        logic le;
        logic gt;
    } t_cmp_res;

endpackage

/* hdl/hct_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module hct_ram #(
    parameter int WIDTH  = 64,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* hdl/hct_cmp.sv */
// Shared 64-bit compare unit of the checkpoint table.
// Depends on hct_pkg.
`timescale 1ns / 1ps

module hct_cmp (
    input  logic [hct_pkg::HEIGHT_W-1:0] i_a,
    input  logic [hct_pkg::HEIGHT_W-1:0] i_b,
    input  logic [hct_pkg::HEIGHT_W-1:0] i_c,
    output hct_pkg::t_cmp_res            o_res
);
    import hct_pkg::*;

    assign o_res.eq = (i_a == i_b);
    assign o_res.le = (i_a <= i_b);
    assign o_res.gt = (i_a > i_c);

endmodule

/* hdl/height_checkpoint_table.sv */
// Top level of the height checkpoint table: sequencer, storage and result register.
// Depends on hct_pkg, hct_ram and hct_cmp.
`timescale 1ns / 1ps
//
// Input channel: i_in_valid / o_in_stall with request type, height, chain height
// and the four hash words. A transaction is taken when valid is high and stall is low.
// Output channel: o_out_valid / i_out_stall with status, passed, is_checkpoint and
// in_zone, exactly one result transaction per request.
// Each request runs through a sequencer around one shared 64-bit compare unit:
// one zone compare, a scan of the stored heights at one entry per cycle from the
// height RAM, one hash RAM read when an insert or check matches a stored height,
// and a finish step; the unused request type goes from the zone compare straight
// to the finish step. The scan stops at a matching height for insert and check;
// a query scans every stored entry. o_in_stall stays high through the finish
// state, so the next request is taken only once the sequencer is back in idle.
// The result sits in an output register; the next request may be accepted while
// it waits, but a request cannot finish while the receiver stalls an earlier result.
// Reset empties the table (entry count cleared) and drops any pending result; the
// RAM contents are not cleared, and only entries below the count are ever read.

module height_checkpoint_table #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [1:0]                   i_req_type,
    input  logic [hct_pkg::HEIGHT_W-1:0] i_height,
    input  logic [hct_pkg::HEIGHT_W-1:0] i_chain_height,
    input  logic [hct_pkg::HEIGHT_W-1:0] i_hash_w0,
    input  logic [hct_pkg::HEIGHT_W-1:0] i_hash_w1,
    input  logic [hct_pkg::HEIGHT_W-1:0] i_hash_w2,
    input  logic [hct_pkg::HEIGHT_W-1:0] i_hash_w3,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [1:0]                   o_status,
    output logic                         o_passed,
    output logic                         o_is_checkpoint,
    output logic                         o_in_zone
);
    import hct_pkg::*;

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    t_state                r_state, n_state;
    logic [CW-1:0]         r_count, n_count;
    logic [HEIGHT_W-1:0]   r_highest, n_highest;
    logic                  r_out_valid, n_out_valid;

    logic [1:0]            r_req, n_req;
    logic [HEIGHT_W-1:0]   r_height, n_height;
    logic [HEIGHT_W-1:0]   r_chain, n_chain;
    logic [HASH_W-1:0]     r_hash, n_hash;
    logic [CW-1:0]         r_addr, n_addr;
    logic                  r_pend, n_pend;
    logic [AW-1:0]         r_pend_idx, n_pend_idx;
    logic                  r_found, n_found;
    logic [AW-1:0]         r_idx, n_idx;
    logic [HEIGHT_W-1:0]   r_best, n_best;
    logic                  r_le, n_le;
    logic [1:0]            r_status, n_status;
    logic                  r_passed, n_passed;
    logic                  r_is_cp, n_is_cp;
    logic                  r_zone, n_zone;

    logic                  ht_re;
    logic                  hs_re;
    logic                  tbl_we;
    logic [HEIGHT_W-1:0]   ht_rdata;
    logic [HASH_W-1:0]     hs_rdata;
    logic [HEIGHT_W-1:0]   cmp_a, cmp_b;
    t_cmp_res              cmp;
    logic                  hash_eq;

    hct_ram #(.WIDTH(HEIGHT_W), .DEPTH(TABLE_DEPTH), .ADDR_W(AW)) u_height_ram (
        .i_clk   (i_clk),
        .i_we    (tbl_we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (r_height),
        .i_re    (ht_re),
        .i_raddr (r_addr[AW-1:0]),
        .o_rdata (ht_rdata)
    );

    hct_ram #(.WIDTH(HASH_W), .DEPTH(TABLE_DEPTH), .ADDR_W(AW)) u_hash_ram (
        .i_clk   (i_clk),
        .i_we    (tbl_we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (r_hash),
        .i_re    (hs_re),
        .i_raddr (r_idx),
        .o_rdata (hs_rdata)
    );

    assign cmp_a = (r_state == S_SCAN) ? ht_rdata : r_height;
    assign cmp_b = (r_state == S_ZONE) ? r_highest :
                   ((r_req == REQ_QUERY) ? r_chain : r_height);

    hct_cmp u_cmp (
        .i_a   (cmp_a),
        .i_b   (cmp_b),
        .i_c   (r_best),
        .o_res (cmp)
    );

    assign hash_eq = (hs_rdata == r_hash);

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_highest   = r_highest;
        n_out_valid = r_out_valid;
        n_req       = r_req;
        n_height    = r_height;
        n_chain     = r_chain;
        n_hash      = r_hash;
        n_addr      = r_addr;
        n_pend      = r_pend;
        n_pend_idx  = r_pend_idx;
        n_found     = r_found;
        n_idx       = r_idx;
        n_best      = r_best;
        n_le        = r_le;
        n_status    = r_status;
        n_passed    = r_passed;
        n_is_cp     = r_is_cp;
        n_zone      = r_zone;
        ht_re       = 1'b0;
        hs_re       = 1'b0;
        tbl_we      = 1'b0;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_req    = i_req_type;
                    n_height = i_height;
                    n_chain  = i_chain_height;
                    n_hash   = {i_hash_w3, i_hash_w2, i_hash_w1, i_hash_w0};
                    n_addr   = '0;
                    n_pend   = 1'b0;
                    n_found  = 1'b0;
                    n_best   = '0;
                    n_state  = S_ZONE;
                end
            end
            S_ZONE: begin
                n_le    = cmp.le;
                n_state = (r_req == REQ_UNUSED) ? S_FIN : S_SCAN;
            end
            S_SCAN: begin
                if (r_pend && cmp.eq && (r_req != REQ_QUERY)) begin
                    n_found = 1'b1;
                    n_idx   = r_pend_idx;
                    n_pend  = 1'b0;
                    n_state = S_HRD;
                end else begin
                    if (r_pend && (r_req == REQ_QUERY) && cmp.le && (!r_found || cmp.gt)) begin
                        n_best  = ht_rdata;
                        n_found = 1'b1;
                    end
                    if (r_addr != r_count) begin
                        ht_re      = 1'b1;
                        n_pend     = 1'b1;
                        n_pend_idx = r_addr[AW-1:0];
                        n_addr     = r_addr + CW'(1);
                    end else begin
                        n_pend = 1'b0;
                        if (!r_pend) begin
                            n_state = S_FIN;
                        end
                    end
                end
            end
            S_HRD: begin
                hs_re   = 1'b1;
                n_state = S_FIN;
            end
            S_FIN: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_status    = ST_OK;
                    n_passed    = 1'b0;
                    n_is_cp     = 1'b0;
                    n_zone      = 1'b0;
                    n_state     = S_IDLE;
                    case (r_req)
                        REQ_INSERT: begin
                            if (r_found) begin
                                n_status = hash_eq ? ST_OK : ST_CONFLICT;
                            end else if (r_count == CW'(TABLE_DEPTH)) begin
                                n_status = ST_FULL;
                            end else begin
                                tbl_we  = 1'b1;
                                n_count = r_count + CW'(1);
                                if ((r_count == '0) || !r_le) begin
                                    n_highest = r_height;
                                end
                            end
                        end
                        REQ_CHECK: begin
                            n_is_cp  = r_found;
                            n_passed = !r_found || hash_eq;
                            n_zone   = (r_count != '0) && r_le;
                        end
                        REQ_QUERY: begin
                            n_zone   = (r_count != '0) && r_le;
                            n_passed = (r_height != '0) && (!r_found || cmp.gt);
                        end
                        default: begin
                            n_status = ST_OK;
                        end
                    endcase
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_highest   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_highest   <= n_highest;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req      <= n_req;
        r_height   <= n_height;
        r_chain    <= n_chain;
        r_hash     <= n_hash;
        r_addr     <= n_addr;
        r_pend     <= n_pend;
        r_pend_idx <= n_pend_idx;
        r_found    <= n_found;
        r_idx      <= n_idx;
        r_best     <= n_best;
        r_le       <= n_le;
        r_status   <= n_status;
        r_passed   <= n_passed;
        r_is_cp    <= n_is_cp;
        r_zone     <= n_zone;
    end

    assign o_in_stall      = (r_state != S_IDLE);
    assign o_out_valid     = r_out_valid;
    assign o_status        = r_status;
    assign o_passed        = r_passed;
    assign o_is_checkpoint = r_is_cp;
    assign o_in_zone       = r_zone;

endmodule

/* hdl/hct_checker.sv */
// Port-level checker of the height checkpoint table, bound to the top level.
// Depends on hct_pkg and height_checkpoint_table_macros.svh.
`timescale 1ns / 1ps

module hct_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_in_valid,
    input logic                         o_in_stall,
    input logic [1:0]                   i_req_type,
    input logic [hct_pkg::HEIGHT_W-1:0] i_height,
    input logic [hct_pkg::HEIGHT_W-1:0] i_chain_height,
    input logic [hct_pkg::HEIGHT_W-1:0] i_hash_w0,
    input logic [hct_pkg::HEIGHT_W-1:0] i_hash_w1,
    input logic [hct_pkg::HEIGHT_W-1:0] i_hash_w2,
    input logic [hct_pkg::HEIGHT_W-1:0] i_hash_w3,
    input logic                         o_out_valid,
    input logic                         i_out_stall,
    input logic [1:0]                   o_status,
    input logic                         o_passed,
    input logic                         o_is_checkpoint,
    input logic                         o_in_zone
);
    import hct_pkg::*;
    `include "height_checkpoint_table_macros.svh"

    logic [4:0]              out_word;
    logic [2+6*HEIGHT_W-1:0] in_word;
    logic                    out_wait;
    logic                    in_wait;
    logic                    in_take;
    logic                    status_known;
    logic                    rejected;
    logic                    flags_clear;

    assign out_word     = {o_status, o_passed, o_is_checkpoint, o_in_zone};
    assign in_word      = {i_req_type, i_height, i_chain_height,
                           i_hash_w3, i_hash_w2, i_hash_w1, i_hash_w0};
    assign out_wait     = o_out_valid && i_out_stall;
    assign in_wait      = i_in_valid && o_in_stall;
    assign in_take      = i_in_valid && !o_in_stall;
    assign status_known = o_status inside {ST_OK, ST_CONFLICT, ST_FULL};
    assign rejected     = o_out_valid && (o_status != ST_OK);
    assign flags_clear  = !o_passed && !o_is_checkpoint && !o_in_zone;

    `HCT_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, out_wait, o_out_valid && $stable(out_word))
    `HCT_ASSERT_NXT(a_in_hold, i_clk, i_rst_n, in_wait, i_in_valid && $stable(in_word))
    `HCT_ASSERT_NXT(a_busy_after_accept, i_clk, i_rst_n, in_take, o_in_stall)
    `HCT_ASSERT_NOW(a_status_code, i_clk, i_rst_n, o_out_valid, status_known)
    `HCT_ASSERT_NOW(a_reject_clean, i_clk, i_rst_n, rejected, flags_clear)

endmodule

bind height_checkpoint_table hct_checker u_hct_checker (.*);
